[src/scc_pkg.sv]
// Package with payload types, stage map and per-stage logic of the sphere-capsule distance pipe.
`default_nettype none
package scc_pkg;

  localparam int NORM_BITS  = 30;
  localparam int TDIV_STEPS = 30;
  localparam int SQRT_STEPS = 33;
  localparam int NDIV_STEPS = 31;

  localparam int ST_MUL  = 1;
  localparam int ST_SUM  = 2;
  localparam int ST_CLS  = 3;
  localparam int ST_TDIV = 4;
  localparam int ST_TMUL = ST_TDIV + TDIV_STEPS;
  localparam int ST_V    = ST_TMUL + 1;
  localparam int ST_ABS  = ST_V + 1;
  localparam int ST_SQ   = ST_ABS + 1;
  localparam int ST_D2   = ST_SQ + 1;
  localparam int ST_SQRT = ST_D2 + 1;
  localparam int ST_SEP  = ST_SQRT + SQRT_STEPS;
  localparam int ST_NDIV = ST_SEP + 1;
  localparam int ST_OUT  = ST_NDIV + NDIV_STEPS;
  localparam int NSTG    = ST_OUT + 1;

  localparam logic [30:0] T_ONE = 31'(1 << NORM_BITS);
  localparam logic [31:0] N_ONE = 32'(1 << NORM_BITS);

  typedef struct packed {
    logic signed [31:0] sphere_x;
    logic signed [31:0] sphere_y;
    logic signed [31:0] sphere_z;
    logic [30:0]        ball_radius;
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_start_z;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic signed [31:0] seg_end_z;
    logic [30:0]        capsule_radius;
  } scc_in_t;

  typedef struct packed {
    logic signed [31:0] separation;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic               zero_distance;
  } scc_out_t;

  typedef struct packed {
    logic [2:0][32:0] d;
    logic [2:0][32:0] w;
    logic [31:0]      rsum;
    logic [2:0][64:0] dd;
    logic [2:0][65:0] wd;
    logic [65:0]      len2;
    logic [66:0]      proj;
    logic             div_en;
    logic [65:0]      drem;
    logic [30:0]      t;
    logic [2:0][64:0] td;
    logic [2:0][33:0] v;
    logic [2:0][31:0] vmag;
    logic [2:0]       vneg;
    logic [2:0][63:0] sq;
    logic [65:0]      dist2;
    logic [34:0]      srem;
    logic [32:0]      sroot;
    logic [31:0]      sep;
    logic [2:0][62:0] num;
    logic [2:0][32:0] nrem;
    logic [2:0][30:0] nq;
    scc_out_t         res;
  } scc_pipe_t;

  function automatic scc_pipe_t scc_stage(input int k, input scc_pipe_t p);
    scc_pipe_t          q;
    logic signed [66:0] sp;
    logic [66:0]        r67;
    logic signed [65:0] y;
    logic signed [65:0] ys;
    logic signed [34:0] sv;
    logic [33:0]        a34;
    logic [36:0]        r37;
    logic [36:0]        tr37;
    logic signed [34:0] sdiff;
    logic [33:0]        r34;
    logic [31:0]        m;
    int                 j;
    q = p;
    if (k == ST_MUL) begin
      for (int i = 0; i < 3; i++) begin
        sp = 67'($signed(p.d[i]) * $signed(p.d[i]));
        q.dd[i] = sp[64:0];
        sp = 67'($signed(p.w[i]) * $signed(p.d[i]));
        q.wd[i] = sp[65:0];
      end
    end else if (k == ST_SUM) begin
      q.len2 = 66'(p.dd[0]) + 66'(p.dd[1]) + 66'(p.dd[2]);
      q.proj = 67'($signed(p.wd[0])) + 67'($signed(p.wd[1])) + 67'($signed(p.wd[2]));
    end else if (k == ST_CLS) begin
      q.drem = p.proj[65:0];
      q.t = '0;
      q.div_en = 1'b0;
      if (p.len2 == '0 || p.proj[66] || p.proj == '0) begin
        q.t = '0;
      end else if (p.proj >= {1'b0, p.len2}) begin
        q.t = T_ONE;
      end else begin
        q.div_en = 1'b1;
      end
    end else if (k >= ST_TDIV && k < ST_TMUL) begin
      if (p.div_en) begin
        r67 = {p.drem, 1'b0};
        if (r67 >= {1'b0, p.len2}) begin
          r67 = r67 - {1'b0, p.len2};
          q.t = {p.t[29:0], 1'b1};
        end else begin
          q.t = {p.t[29:0], 1'b0};
        end
        q.drem = r67[65:0];
      end
    end else if (k == ST_TMUL) begin
      for (int i = 0; i < 3; i++) begin
        q.td[i] = 65'($signed({1'b0, p.t}) * $signed(p.d[i]));
      end
    end else if (k == ST_V) begin
      for (int i = 0; i < 3; i++) begin
        y = 66'($signed(p.td[i])) + 66'sd536870912;
        ys = y >>> NORM_BITS;
        sv = ys[34:0];
        sv = sv - 35'($signed(p.w[i]));
        q.v[i] = sv[33:0];
      end
    end else if (k == ST_ABS) begin
      for (int i = 0; i < 3; i++) begin
        a34 = p.v[i][33] ? (34'd0 - p.v[i]) : p.v[i];
        q.vmag[i] = a34[31:0];
        q.vneg[i] = p.v[i][33];
      end
    end else if (k == ST_SQ) begin
      for (int i = 0; i < 3; i++) begin
        q.sq[i] = 64'(p.vmag[i]) * 64'(p.vmag[i]);
      end
    end else if (k == ST_D2) begin
      q.dist2 = 66'(p.sq[0]) + 66'(p.sq[1]) + 66'(p.sq[2]);
      q.srem = '0;
      q.sroot = '0;
    end else if (k >= ST_SQRT && k < ST_SEP) begin
      j = k - ST_SQRT;
      r37 = {p.srem, p.dist2[2 * (SQRT_STEPS - 1 - j) +: 2]};
      tr37 = {2'b00, p.sroot, 2'b01};
      if (r37 >= tr37) begin
        r37 = r37 - tr37;
        q.sroot = {p.sroot[31:0], 1'b1};
      end else begin
        q.sroot = {p.sroot[31:0], 1'b0};
      end
      q.srem = r37[34:0];
    end else if (k == ST_SEP) begin
      sdiff = $signed({2'b00, p.sroot}) - $signed({3'b000, p.rsum});
      if (sdiff > 35'sd2147483647) begin
        q.sep = 32'h7FFF_FFFF;
      end else if (sdiff < -35'sd2147483648) begin
        q.sep = 32'h8000_0000;
      end else begin
        q.sep = sdiff[31:0];
      end
      for (int i = 0; i < 3; i++) begin
        q.num[i] = 63'({p.vmag[i], 30'd0}) + 63'(p.sroot[32:1]);
        q.nrem[i] = 33'(q.num[i][62:31]);
        q.nq[i] = '0;
      end
    end else if (k >= ST_NDIV && k < ST_OUT) begin
      j = k - ST_NDIV;
      for (int i = 0; i < 3; i++) begin
        r34 = {p.nrem[i], p.num[i][NDIV_STEPS - 1 - j]};
        if (r34 >= {1'b0, p.sroot}) begin
          r34 = r34 - {1'b0, p.sroot};
          q.nq[i] = {p.nq[i][29:0], 1'b1};
        end else begin
          q.nq[i] = {p.nq[i][29:0], 1'b0};
        end
        q.nrem[i] = r34[32:0];
      end
    end else if (k == ST_OUT) begin
      q.res.separation = p.sep;
      q.res.zero_distance = (p.sroot == '0);
      for (int i = 0; i < 3; i++) begin
        m = (32'(p.nq[i]) > N_ONE) ? N_ONE : 32'(p.nq[i]);
        if (p.sroot == '0) begin
          m = '0;
        end else if (p.vneg[i]) begin
          m = 32'd0 - m;
        end
        if (i == 0) begin
          q.res.normal_x = m;
        end else if (i == 1) begin
          q.res.normal_y = m;
        end else begin
          q.res.normal_z = m;
        end
      end
    end
    return q;
  endfunction

endpackage
`default_nettype wire

[src/scc_if.sv]
// Valid-ready channel interfaces for the input and result items.
`default_nettype none
interface scc_in_if import scc_pkg::*; ();
  logic    valid;
  logic    ready;
  scc_in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface scc_out_if import scc_pkg::*; ();
  logic     valid;
  logic     ready;
  scc_out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[src/sphere_capsule_contact_distance.sv]
// Top level: pipelined sphere to capsule separation and contact normal.
// Each item on in_ch carries a sphere and a capsule segment; each item on
// out_ch carries the signed separation, the unit normal from the sphere
// center to the closest segment point, and a flag for zero distance.
// Both channels are valid-ready; an item moves when valid and ready are high.
// The pipe has 105 register stages; an accepted item enters the first one,
// and its result is offered from the last one. One item is accepted per
// cycle unless the pipe is full and stalled; up to 105 items are in flight.
// The length is set by the three bit-per-stage units: the 30-stage divider
// for the segment parameter, the 33-stage square root for the distance,
// and the 31-stage divider for the normal.
// Every stage has its own valid bit and moves on when it is empty or when
// the stage after it moves, so a stalled receiver fills empty stages first
// and the input keeps taking items until the pipe is full. Nothing is lost
// or repeated. Synchronous reset clears all valid bits; the data registers
// are not reset.
`default_nettype none
module sphere_capsule_contact_distance import scc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  scc_in_if.sink     in_ch,
  scc_out_if.source  out_ch
);

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;
  scc_pipe_t       stage_r   [NSTG];
  scc_pipe_t       stage_nxt [NSTG];

  always_comb begin
    stage_nxt[0] = '0;
    stage_nxt[0].d[0] = 33'(in_ch.data.seg_end_x) - 33'(in_ch.data.seg_start_x);
    stage_nxt[0].d[1] = 33'(in_ch.data.seg_end_y) - 33'(in_ch.data.seg_start_y);
    stage_nxt[0].d[2] = 33'(in_ch.data.seg_end_z) - 33'(in_ch.data.seg_start_z);
    stage_nxt[0].w[0] = 33'(in_ch.data.sphere_x) - 33'(in_ch.data.seg_start_x);
    stage_nxt[0].w[1] = 33'(in_ch.data.sphere_y) - 33'(in_ch.data.seg_start_y);
    stage_nxt[0].w[2] = 33'(in_ch.data.sphere_z) - 33'(in_ch.data.seg_start_z);
    stage_nxt[0].rsum = 32'(in_ch.data.ball_radius) + 32'(in_ch.data.capsule_radius);
  end

  assign en[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;

  genvar k;
  generate
    for (k = 0; k < NSTG - 1; k++) begin : g_en
      assign en[k] = !vld_r[k] || en[k+1];
    end
    for (k = 1; k < NSTG; k++) begin : g_stage
      always_comb begin
        stage_nxt[k] = scc_stage(k, stage_r[k-1]);
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en[k]) begin
          stage_r[k] <= stage_nxt[k];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en[0]) begin
      vld_r[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      stage_r[0] <= stage_nxt[0];
    end
  end

  assign in_ch.ready  = en[0];
  assign out_ch.valid = vld_r[NSTG-1];
  assign out_ch.data  = stage_r[NSTG-1].res;

endmodule
`default_nettype wire

[src/scc_checker.sv]
// Port-level checker for the sphere-capsule distance block and its bind.
`default_nettype none
module scc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] normal_x,
  input wire logic [31:0] normal_y,
  input wire logic [31:0] normal_z,
  input wire logic        zero_distance
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_flow: assert property (@(posedge clk) out_ready |-> in_ready)
    else $error("input stalled while receiver is ready");

  a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_distance |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("nonzero normal with zero distance");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(normal_x) <= 32'sd1073741824 &&
                   $signed(normal_x) >= -32'sd1073741824 &&
                   $signed(normal_y) <= 32'sd1073741824 &&
                   $signed(normal_y) >= -32'sd1073741824 &&
                   $signed(normal_z) <= 32'sd1073741824 &&
                   $signed(normal_z) >= -32'sd1073741824))
    else $error("normal component out of range");

endmodule

bind sphere_capsule_contact_distance scc_checker u_scc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .normal_x     (out_ch.data.normal_x),
  .normal_y     (out_ch.data.normal_y),
  .normal_z     (out_ch.data.normal_z),
  .zero_distance(out_ch.data.zero_distance)
);
`default_nettype wire
